>>> src/sftb_pkg.sv
package sftb_pkg;

  localparam int MAX_RESULTS = 8;
  localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

  typedef enum logic [2:0] {
    OP_TICK      = 3'd0,
    OP_START_ONE = 3'd1,
    OP_START_CYC = 3'd2,
    OP_RETRIG    = 3'd3,
    OP_STOP      = 3'd4,
    OP_QUERY     = 3'd5
  } op_t;

  typedef struct packed {
    logic [2:0] operation;
    logic [2:0] timer_index;
    logic [7:0] delay_ticks;
  } sftb_in_t;

  typedef struct packed {
    logic [2:0] which_timer;
    logic       expired;
    logic       is_running;
    logic       last_result;
  } sftb_out_t;

endpackage

>>> src/software_timer_bank_core.sv
// command: result strobed the cycle after the transfer, busy stays low, one command per cycle
// tick: busy through the SWEEP, DRAIN and FLUSH states, as the count and target memories are swept
//   (one timer per cycle); each of up to MAX_RESULTS expiries is strobed once the next one is
//   found, the last one from FLUSH; no new tick is taken until the sweep is through
// results are strobed for one cycle and cannot be stalled by the receiver
// reset (synchronous, active low): all timers stopped, targets read as zero; counts are not reset
module software_timer_bank_core #(
  parameter int NUM_TIMERS  = 8,
  parameter int COUNT_WIDTH = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  sftb_pkg::sftb_in_t  in_cmd,
  output logic                busy,
  output logic                out_valid,
  output sftb_pkg::sftb_out_t out_res
);
  import sftb_pkg::*;

  localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SWEEP = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_FLUSH = 4'b1000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [IDX_W-1:0]       rd_idx_r, rd_idx_nxt;
  logic                   p_vld_r, p_vld_nxt;
  logic [IDX_W-1:0]       p_idx_r;
  logic [COUNT_WIDTH-1:0] cnt_rd_r, tgt_rd_r;
  logic [NUM_TIMERS-1:0]  run_r, run_nxt;
  logic [NUM_TIMERS-1:0]  cyc_r, cyc_nxt;
  logic [NUM_TIMERS-1:0]  tgt_vld_r, tgt_vld_nxt;
  logic                   pend_vld_r, pend_vld_nxt;
  sftb_out_t              pend_r, pend_nxt;
  logic [RES_CNT_W-1:0]   res_cnt_r, res_cnt_nxt;
  logic                   out_valid_r, out_valid_nxt;
  sftb_out_t              out_res_r, out_res_nxt;

  logic [COUNT_WIDTH-1:0] cnt_mem [NUM_TIMERS];
  logic [COUNT_WIDTH-1:0] tgt_mem [NUM_TIMERS];
  logic                   cnt_we, tgt_we;
  logic [IDX_W-1:0]       cnt_wa;
  logic [COUNT_WIDTH-1:0] cnt_wd, tgt_wd;

  logic                   accept;
  logic [IDX_W-1:0]       cmd_idx;
  logic                   cmd_in_range;
  logic [COUNT_WIDTH-1:0] cnt_inc, tgt_eff;
  logic                   p_run, p_cyc, p_act, p_hit, p_emit;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  assign cmd_idx      = IDX_W'(in_cmd.timer_index);
  assign cmd_in_range = int'(in_cmd.timer_index) < NUM_TIMERS;

  // shared increment and compare, one timer per cycle
  assign p_run   = run_r[p_idx_r];
  assign p_cyc   = cyc_r[p_idx_r];
  assign cnt_inc = cnt_rd_r + COUNT_WIDTH'(1);
  assign tgt_eff = tgt_vld_r[p_idx_r] ? tgt_rd_r : '0;
  assign p_act   = p_vld_r && p_run;
  assign p_hit   = p_act && (cnt_inc == tgt_eff);
  assign p_emit  = p_hit && (res_cnt_r < RES_CNT_W'(MAX_RESULTS));

  always_comb begin
    state_nxt     = state_r;
    rd_idx_nxt    = rd_idx_r;
    p_vld_nxt     = 1'b0;
    run_nxt       = run_r;
    cyc_nxt       = cyc_r;
    tgt_vld_nxt   = tgt_vld_r;
    pend_vld_nxt  = pend_vld_r;
    pend_nxt      = pend_r;
    res_cnt_nxt   = res_cnt_r;
    out_valid_nxt = 1'b0;
    out_res_nxt   = out_res_r;
    cnt_we        = 1'b0;
    cnt_wa        = cmd_idx;
    cnt_wd        = '0;
    tgt_we        = 1'b0;
    tgt_wd        = COUNT_WIDTH'(in_cmd.delay_ticks);

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_cmd.operation == OP_TICK) begin
            state_nxt    = ST_SWEEP;
            rd_idx_nxt   = '0;
            res_cnt_nxt  = '0;
            pend_vld_nxt = 1'b0;
          end else begin
            if (cmd_in_range) begin
              case (in_cmd.operation)
                OP_START_ONE, OP_START_CYC: begin
                  cnt_we               = 1'b1;
                  tgt_we               = 1'b1;
                  tgt_vld_nxt[cmd_idx] = 1'b1;
                  cyc_nxt[cmd_idx]     = (in_cmd.operation == OP_START_CYC);
                  run_nxt[cmd_idx]     = 1'b1;
                end
                OP_RETRIG: begin
                  cnt_we           = 1'b1;
                  run_nxt[cmd_idx] = 1'b1;
                end
                OP_STOP: begin
                  run_nxt[cmd_idx] = 1'b0;
                end
                default: begin
                end
              endcase
            end
            out_valid_nxt           = 1'b1;
            out_res_nxt.which_timer = in_cmd.timer_index;
            out_res_nxt.expired     = 1'b0;
            out_res_nxt.is_running  = cmd_in_range ? run_nxt[cmd_idx] : 1'b0;
            out_res_nxt.last_result = 1'b1;
          end
        end
      end
      ST_SWEEP: begin
        p_vld_nxt = 1'b1;
        if (rd_idx_r == LAST_IDX) begin
          state_nxt = ST_DRAIN;
        end else begin
          rd_idx_nxt = rd_idx_r + IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (pend_vld_r) begin
          out_valid_nxt           = 1'b1;
          out_res_nxt             = pend_r;
          out_res_nxt.last_result = 1'b1;
          pend_vld_nxt            = 1'b0;
        end
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // timer in the process stage of the sweep
    if (p_act) begin
      cnt_we = 1'b1;
      cnt_wa = p_idx_r;
      cnt_wd = (p_hit && p_cyc) ? '0 : cnt_inc;
      if (p_hit && !p_cyc) begin
        run_nxt[p_idx_r] = 1'b0;
      end
    end

    // an expiry is held back one find so the final one can carry last_result
    if (p_emit) begin
      if (pend_vld_r) begin
        out_valid_nxt = 1'b1;
        out_res_nxt   = pend_r;
      end
      pend_vld_nxt         = 1'b1;
      pend_nxt.which_timer = 3'(p_idx_r);
      pend_nxt.expired     = 1'b1;
      pend_nxt.is_running  = p_cyc;
      pend_nxt.last_result = 1'b0;
      res_cnt_nxt          = res_cnt_r + RES_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_idx_r    <= '0;
      p_vld_r     <= 1'b0;
      run_r       <= '0;
      cyc_r       <= '0;
      tgt_vld_r   <= '0;
      pend_vld_r  <= 1'b0;
      res_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_idx_r    <= rd_idx_nxt;
      p_vld_r     <= p_vld_nxt;
      run_r       <= run_nxt;
      cyc_r       <= cyc_nxt;
      tgt_vld_r   <= tgt_vld_nxt;
      pend_vld_r  <= pend_vld_nxt;
      res_cnt_r   <= res_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_idx_r   <= rd_idx_r;
    pend_r    <= pend_nxt;
    out_res_r <= out_res_nxt;
  end

  // count and target memories
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    cnt_rd_r <= cnt_mem[rd_idx_r];
  end

  always_ff @(posedge clk) begin
    if (tgt_we) begin
      tgt_mem[cmd_idx] <= tgt_wd;
    end
    tgt_rd_r <= tgt_mem[rd_idx_r];
  end

  a_cmd_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_cmd.operation != OP_TICK) |=>
      (out_valid && out_res.last_result && !out_res.expired))
    else $error("command transfer not followed by its result");

  a_tick_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_cmd.operation == OP_TICK) |=> !out_valid)
    else $error("result strobed right after tick transfer");

  a_expiry_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.expired) |-> $past(busy))
    else $error("expiry result outside a tick sweep");

  a_cmd_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_res.expired) |-> out_res.last_result)
    else $error("command result without last_result");

endmodule
